>>> rtl/core/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// shared types, reply constants and checksum fold for the syn-ack responder
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int unsigned SUM_W = 20;
  localparam logic [3:0] LAST_IDX = 4'd9;

  localparam logic [31:0] WORD_VER_LEN  = 32'h4500_0028;
  localparam logic [15:0] TTL_PROTO     = 16'h4006;
  localparam logic [31:0] WORD_OFF_WIN  = 32'h5012_16D0;
  localparam logic [15:0] TCP_PSEUDO_K  = 16'h001A;
  localparam logic [15:0] IP_CONST_SUM  = 16'h852E;

  typedef logic [SUM_W-1:0] csum_acc_t;

  typedef struct packed {
    logic [31:0] peer_address;
    logic [31:0] local_address;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] ack_number;
    logic        syn_flag;
    logic [15:0] fresh_ip_id;
    logic [31:0] fresh_sequence;
  } seg_t;

  typedef struct packed {
    logic [31:0] peer_address;
    logic [31:0] local_address;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] ack_number;
    logic [15:0] fresh_ip_id;
    logic [31:0] fresh_sequence;
    csum_acc_t   tcp_sum;
    csum_acc_t   ip_sum;
  } reply_t;

  function automatic logic [15:0] fold_invert(input csum_acc_t acc);
    logic [16:0] s;
    logic [15:0] t;
    s = {1'b0, acc[15:0]} + 17'(acc[SUM_W-1:16]);
    t = s[15:0] + {15'd0, s[16]};
    return ~t;
  endfunction

endpackage

>>> rtl/core/tsa_if.sv
// ----------------------------------------------------------------------------
// tsa_if
// valid/ready channels of the syn-ack responder
// ----------------------------------------------------------------------------
interface tsa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] peer_address;
  logic [31:0] local_address;
  logic [15:0] peer_port;
  logic [15:0] local_port;
  logic [31:0] peer_sequence;
  logic        syn_flag;
  logic        ack_flag;
  logic [15:0] fresh_ip_id;
  logic [31:0] fresh_sequence;

  modport source (
    output valid, peer_address, local_address, peer_port, local_port,
           peer_sequence, syn_flag, ack_flag, fresh_ip_id, fresh_sequence,
    input  ready
  );
  modport sink (
    input  valid, peer_address, local_address, peer_port, local_port,
           peer_sequence, syn_flag, ack_flag, fresh_ip_id, fresh_sequence,
    output ready
  );
endinterface

interface tsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, packet_word, word_index, last_word, input ready);
  modport sink (input valid, packet_word, word_index, last_word, output ready);
endinterface

interface tsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/tcp_syn_ack_responder_top.sv
// ----------------------------------------------------------------------------
// tcp_syn_ack_responder_top
// answers SYN segments on the listen port with a 40-byte ipv4/tcp syn-ack
// ----------------------------------------------------------------------------
// A segment beat is registered on acceptance; in the next cycle the port match
// and both header sums are formed, and once the output buffer is free the reply
// is loaded; its first beat shows in the cycle after the load. A reply leaves as
// ten beats on the single 32-bit output channel, so a matching segment is taken
// only as the current reply's last beat leaves and waits in the input register
// while it drains. Segments that do not match produce no beats and are consumed
// at one per cycle unless a stalled matching segment is ahead of them.
module tcp_syn_ack_responder_top (
  input  logic       clk,
  input  logic       rst_n,
  tsa_in_if.sink     in_if,
  tsa_out_if.source  out_if,
  tsa_cfg_if.sink    cfg_if
);

  logic [15:0]        listen_port_r;
  logic               s1_valid_r;
  tsa_pkg::seg_t      s1_seg_r;
  logic               s1_match;
  logic               s1_adv;
  logic               load_ready;
  tsa_pkg::reply_t    load_reply;
  tsa_pkg::csum_acc_t tcp_sum;
  tsa_pkg::csum_acc_t ip_sum;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r <= 16'd0;
    end else if (cfg_if.valid) begin
      listen_port_r <= cfg_if.data;
    end
  end

  assign s1_match    = s1_seg_r.syn_flag && (s1_seg_r.local_port == listen_port_r);
  assign s1_adv      = s1_valid_r && (!s1_match || load_ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_seg_r.peer_address   <= in_if.peer_address;
      s1_seg_r.local_address  <= in_if.local_address;
      s1_seg_r.peer_port      <= in_if.peer_port;
      s1_seg_r.local_port     <= in_if.local_port;
      s1_seg_r.ack_number     <= in_if.peer_sequence + 32'd1;
      s1_seg_r.syn_flag       <= in_if.syn_flag;
      s1_seg_r.fresh_ip_id    <= in_if.fresh_ip_id;
      s1_seg_r.fresh_sequence <= in_if.fresh_sequence;
    end
  end

  tsa_csum u_csum (
    .seg     (s1_seg_r),
    .tcp_sum (tcp_sum),
    .ip_sum  (ip_sum)
  );

  always_comb begin
    load_reply.peer_address   = s1_seg_r.peer_address;
    load_reply.local_address  = s1_seg_r.local_address;
    load_reply.peer_port      = s1_seg_r.peer_port;
    load_reply.local_port     = s1_seg_r.local_port;
    load_reply.ack_number     = s1_seg_r.ack_number;
    load_reply.fresh_ip_id    = s1_seg_r.fresh_ip_id;
    load_reply.fresh_sequence = s1_seg_r.fresh_sequence;
    load_reply.tcp_sum        = tcp_sum;
    load_reply.ip_sum         = ip_sum;
  end

  tsa_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r && s1_match),
    .load_ready (load_ready),
    .load_reply (load_reply),
    .out_if     (out_if)
  );

  // a non-last beat is followed by the next word of the same reply
  a_beat_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && !out_if.last_word) |=>
      (out_if.valid && (out_if.word_index == $past(out_if.word_index) + 4'd1)))
    else $error("reply beat order broken");

  // non-matching segments never stall the input
  a_drop_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_match) |-> in_if.ready)
    else $error("dropped segment stalled input");

  // last flag marks exactly word nine
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.last_word == (out_if.word_index == tsa_pkg::LAST_IDX)))
    else $error("last flag mismatch");

  // a reply starts at word zero right after a load
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_match && load_ready) |=>
      (out_if.valid && (out_if.word_index == 4'd0)))
    else $error("reply did not start at word zero");

endmodule

>>> rtl/core/tsa_csum.sv
// ----------------------------------------------------------------------------
// tsa_csum
// unfolded ones-complement sums of the reply tcp and ip headers
// ----------------------------------------------------------------------------
module tsa_csum (
  input  tsa_pkg::seg_t      seg,
  output tsa_pkg::csum_acc_t tcp_sum,
  output tsa_pkg::csum_acc_t ip_sum
);

  function automatic tsa_pkg::csum_acc_t ext(input logic [15:0] v);
    return tsa_pkg::csum_acc_t'(v);
  endfunction

  // pseudo-header, ports, sequence, ack, offset/flags/window
  assign tcp_sum = ext(seg.local_address[31:16]) + ext(seg.local_address[15:0])
                 + ext(seg.peer_address[31:16]) + ext(seg.peer_address[15:0])
                 + ext(seg.local_port) + ext(seg.peer_port)
                 + ext(seg.fresh_sequence[31:16]) + ext(seg.fresh_sequence[15:0])
                 + ext(seg.ack_number[31:16]) + ext(seg.ack_number[15:0])
                 + ext(tsa_pkg::TCP_PSEUDO_K)
                 + ext(tsa_pkg::WORD_OFF_WIN[31:16])
                 + ext(tsa_pkg::WORD_OFF_WIN[15:0]);

  assign ip_sum = ext(tsa_pkg::IP_CONST_SUM) + ext(seg.fresh_ip_id)
                + ext(seg.local_address[31:16]) + ext(seg.local_address[15:0])
                + ext(seg.peer_address[31:16]) + ext(seg.peer_address[15:0]);

endmodule

>>> rtl/core/tsa_serializer.sv
// ----------------------------------------------------------------------------
// tsa_serializer
// holds one reply and sends it as ten 32-bit beats
// ----------------------------------------------------------------------------
module tsa_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  tsa_pkg::reply_t      load_reply,
  tsa_out_if.source            out_if
);

  logic            buf_valid_r, buf_valid_nxt;
  logic [3:0]      idx_r, idx_nxt;
  tsa_pkg::reply_t reply_r;
  logic            out_fire;
  logic            at_last;

  assign at_last    = (idx_r == tsa_pkg::LAST_IDX);
  assign out_fire   = buf_valid_r && out_if.ready;
  assign load_ready = !buf_valid_r || (out_fire && at_last);

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    idx_nxt       = idx_r;
    if (load_valid && load_ready) begin
      buf_valid_nxt = 1'b1;
      idx_nxt       = 4'd0;
    end else if (out_fire) begin
      if (at_last) begin
        buf_valid_nxt = 1'b0;
        idx_nxt       = 4'd0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      reply_r <= load_reply;
    end
  end

  always_comb begin
    case (idx_r)
      4'd0: out_if.packet_word = tsa_pkg::WORD_VER_LEN;
      4'd1: out_if.packet_word = {reply_r.fresh_ip_id, 16'd0};
      4'd2: out_if.packet_word = {tsa_pkg::TTL_PROTO,
                                  tsa_pkg::fold_invert(reply_r.ip_sum)};
      4'd3: out_if.packet_word = reply_r.local_address;
      4'd4: out_if.packet_word = reply_r.peer_address;
      4'd5: out_if.packet_word = {reply_r.local_port, reply_r.peer_port};
      4'd6: out_if.packet_word = reply_r.fresh_sequence;
      4'd7: out_if.packet_word = reply_r.ack_number;
      4'd8: out_if.packet_word = tsa_pkg::WORD_OFF_WIN;
      4'd9: out_if.packet_word = {tsa_pkg::fold_invert(reply_r.tcp_sum), 16'd0};
      default: out_if.packet_word = 32'd0;
    endcase
  end

  assign out_if.valid      = buf_valid_r;
  assign out_if.word_index = idx_r;
  assign out_if.last_word  = at_last;

endmodule
